/* sv/euclidean_rhythm_generator_macros.svh */
`ifndef EUCLIDEAN_RHYTHM_GENERATOR_MACROS_SVH
`define EUCLIDEAN_RHYTHM_GENERATOR_MACROS_SVH
// Assertion helpers.
`define ERG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ERG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/erg_pkg.sv */
`default_nettype none
package erg_pkg;
  localparam int unsigned MaxSteps = 64;
  localparam int unsigned CntW = 7;
  localparam int unsigned IdxW = 6;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [CntW-1:0] hit_count;
    logic [CntW-1:0] pattern_length;
  } req_t;

  typedef struct packed {
    logic            step_bit;
    logic [IdxW-1:0] step_index;
    logic            last_step;
  } step_t;

  typedef struct packed {
    logic [CntW-1:0] hits;
    logic [CntW-1:0] len;
  } job_t;
endpackage
`default_nettype wire

/* sv/erg_if.sv */
`default_nettype none
interface erg_req_if;
  import erg_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface erg_step_if;
  import erg_pkg::*;
  logic  valid;
  logic  ready;
  step_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* sv/erg_front.sv */
`default_nettype none
module erg_front #(
  parameter int unsigned MAX_STEPS = erg_pkg::MaxSteps
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  erg_req_if.sink            req,
  output erg_pkg::job_t      job_o,
  output logic               job_valid_o,
  input  wire logic          job_ready_i
);
  import erg_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  job_t            sat;
  logic            push, pop;

  function automatic logic [CntW-1:0] sat_f(input logic [CntW-1:0] v);
    logic [CntW-1:0] m;
    m = CntW'(MAX_STEPS);
    return (v > m) ? m : v;
  endfunction

  assign sat.hits  = sat_f(req.payload.hit_count);
  assign sat.len   = sat_f(req.payload.pattern_length);
  assign req.ready = (cnt_q != (PtrW+1)'(QueueDepth));
  assign push      = req.valid && req.ready;
  assign job_valid_o = (cnt_q != '0);
  assign pop       = job_valid_o && job_ready_i;
  assign job_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

/* sv/erg_back.sv */
`default_nettype none
module erg_back #(
  parameter int unsigned MAX_STEPS = erg_pkg::MaxSteps
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  erg_pkg::job_t job_i,
  input  wire logic     job_valid_i,
  output logic          job_ready_o,
  erg_step_if.source    step
);
  import erg_pkg::*;

  localparam int unsigned AW = $clog2(MAX_STEPS);
  localparam int unsigned Depth = 2 ** (AW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_ROUND, S_PAIR, S_FCOPY, S_BCOPY, S_EMIT, S_RD
  } state_e;

  typedef enum logic [1:0] {
    OP_PAIR, OP_FCOPY, OP_BCOPY
  } wr_op_e;

  // two banks per list, ping-pong per round
  logic [MAX_STEPS-1:0] fb_q [Depth];
  logic [CntW-1:0]      fl_q [Depth];
  logic [MAX_STEPS-1:0] bb_q [Depth];
  logic [CntW-1:0]      bl_q [Depth];
  logic [MAX_STEPS-1:0] f_rbits_q, b_rbits_q;
  logic [CntW-1:0]      f_rlen_q, b_rlen_q;

  state_e          state_q;
  logic            bank_q;
  logic [CntW-1:0] fc_q, bc_q, pairs_q, i_q, nb_q, grp_q;
  logic [CntW-1:0] bit_q, n_q, total_q;
  logic            wr_v_q;
  wr_op_e          wr_op_q;
  logic [AW:0]     wr_addr_q;
  logic            out_v_q;
  step_t           out_q;

  logic [CntW-1:0]      fi, bi, gi;
  logic [AW:0]          f_raddr, b_raddr, f_waddr, b_waddr, issue_addr;
  logic                 f_we, b_we, issue;
  wr_op_e               issue_op;
  logic [MAX_STEPS-1:0] f_wbits, b_wbits, cur_bits;
  logic [CntW-1:0]      f_wlen, b_wlen, cur_len;
  logic                 gfront, group_done, emit_fire;
  step_t                emit_s;

  assign fi = fc_q - CntW'(1) - i_q;
  assign bi = bc_q - CntW'(1) - i_q;
  assign gi = grp_q - fc_q;

  assign gfront     = (grp_q < fc_q);
  assign cur_bits   = gfront ? f_rbits_q : b_rbits_q;
  assign cur_len    = gfront ? f_rlen_q : b_rlen_q;
  assign group_done = (bit_q >= cur_len) || (n_q >= CntW'(MAX_STEPS));
  assign emit_fire  = (state_q == S_EMIT) && !group_done && (!out_v_q || step.ready);

  assign emit_s.step_bit   = cur_bits[bit_q[AW-1:0]];
  assign emit_s.step_index = n_q[IdxW-1:0];
  assign emit_s.last_step  = (n_q + CntW'(1) == total_q);

  assign job_ready_o  = (state_q == S_IDLE);
  assign step.valid   = out_v_q;
  assign step.payload = out_q;

  always_comb begin
    f_raddr    = {bank_q, i_q[AW-1:0]};
    b_raddr    = {bank_q, i_q[AW-1:0]};
    issue      = 1'b0;
    issue_op   = OP_PAIR;
    issue_addr = {~bank_q, i_q[AW-1:0]};
    unique case (state_q)
      S_PAIR: begin
        f_raddr = {bank_q, fi[AW-1:0]};
        b_raddr = {bank_q, bi[AW-1:0]};
        issue   = (i_q < pairs_q);
      end
      S_FCOPY: begin
        issue      = (i_q + pairs_q < fc_q);
        issue_op   = OP_FCOPY;
        issue_addr = {~bank_q, nb_q[AW-1:0]};
      end
      S_BCOPY: begin
        issue      = (i_q + pairs_q < bc_q);
        issue_op   = OP_BCOPY;
        issue_addr = {~bank_q, nb_q[AW-1:0]};
      end
      S_RD, S_EMIT: begin
        f_raddr = {bank_q, grp_q[AW-1:0]};
        b_raddr = {bank_q, gi[AW-1:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    f_we    = wr_v_q && (wr_op_q == OP_PAIR);
    f_waddr = wr_addr_q;
    f_wbits = f_rbits_q | ((f_rlen_q < CntW'(MAX_STEPS)) ? (b_rbits_q << f_rlen_q) : '0);
    f_wlen  = f_rlen_q + b_rlen_q;
    b_we    = wr_v_q && (wr_op_q != OP_PAIR);
    b_waddr = wr_addr_q;
    b_wbits = (wr_op_q == OP_FCOPY) ? f_rbits_q : b_rbits_q;
    b_wlen  = (wr_op_q == OP_FCOPY) ? f_rlen_q : b_rlen_q;
    if (state_q == S_INIT) begin
      f_we    = (i_q < fc_q);
      f_waddr = {1'b0, i_q[AW-1:0]};
      f_wbits = MAX_STEPS'(1);
      f_wlen  = CntW'(1);
      b_we    = (i_q < bc_q);
      b_waddr = {1'b0, i_q[AW-1:0]};
      b_wbits = '0;
      b_wlen  = CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fb_q[f_waddr] <= f_wbits;
      fl_q[f_waddr] <= f_wlen;
    end
    f_rbits_q <= fb_q[f_raddr];
    f_rlen_q  <= fl_q[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bb_q[b_waddr] <= b_wbits;
      bl_q[b_waddr] <= b_wlen;
    end
    b_rbits_q <= bb_q[b_raddr];
    b_rlen_q  <= bl_q[b_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      bank_q  <= 1'b0;
      fc_q <= '0; bc_q <= '0; pairs_q <= '0; i_q <= '0; nb_q <= '0;
      grp_q <= '0; bit_q <= '0; n_q <= '0; total_q <= '0;
      wr_v_q <= 1'b0; wr_op_q <= OP_PAIR; wr_addr_q <= '0;
      out_q <= '0;
    end else begin
      wr_v_q    <= issue;
      wr_op_q   <= issue_op;
      wr_addr_q <= issue_addr;
      if (emit_fire) begin
        out_v_q <= 1'b1;
        out_q   <= emit_s;
      end else if (step.ready) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            fc_q    <= job_i.hits;
            bc_q    <= (job_i.len > job_i.hits) ? job_i.len - job_i.hits : '0;
            total_q <= (job_i.hits > job_i.len) ? job_i.hits : job_i.len;
            i_q     <= '0;
            bank_q  <= 1'b0;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          if (i_q < fc_q || i_q < bc_q) begin
            i_q <= i_q + CntW'(1);
          end else begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          i_q     <= '0;
          nb_q    <= '0;
          grp_q   <= '0;
          n_q     <= '0;
          pairs_q <= (fc_q < bc_q) ? fc_q : bc_q;
          if (fc_q != '0 && bc_q >= CntW'(2)) begin
            state_q <= S_PAIR;
          end else begin
            state_q <= S_RD;
          end
        end
        S_PAIR: begin
          if (issue) begin
            i_q <= i_q + CntW'(1);
          end else begin
            i_q <= '0; state_q <= S_FCOPY;
          end
        end
        S_FCOPY: begin
          if (issue) begin
            nb_q <= nb_q + CntW'(1);
            i_q  <= i_q + CntW'(1);
          end else begin
            i_q <= '0; state_q <= S_BCOPY;
          end
        end
        S_BCOPY: begin
          if (issue) begin
            nb_q <= nb_q + CntW'(1);
            i_q  <= i_q + CntW'(1);
          end else begin
            fc_q <= pairs_q; bc_q <= nb_q; bank_q <= ~bank_q;
            state_q <= S_ROUND;
          end
        end
        S_RD: begin
          if (grp_q < fc_q + bc_q) begin
            bit_q   <= '0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (group_done) begin
            grp_q <= grp_q + CntW'(1); state_q <= S_RD;
          end else if (emit_fire) begin
            n_q   <= n_q + CntW'(1);
            bit_q <= bit_q + CntW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/euclidean_rhythm_generator.sv */
`default_nettype none
// Euclidean rhythm generator: each request (hit_count, pattern_length, both
// saturated at MAX_STEPS) yields max(hits, length) step items, the last one
// marked by last_step; zero hits give all rests, an empty request no items.
// A two-entry request queue decouples intake from the grouping engine, which
// handles one request at a time. A request is taken while the engine is idle,
// then the front and back lists are built, then each grouping round pairs
// front and back groups and copies the leftover front and then back groups
// into the new back list, and a final round check ends the grouping. Emission
// then reads each group and emits its step items; a step item that the output
// holds unaccepted stalls emission. The list memories have registered reads
// and move one group per cycle while pairing and copying.
module euclidean_rhythm_generator #(
  parameter int unsigned MAX_STEPS = erg_pkg::MaxSteps
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  erg_req_if.sink   req,
  erg_step_if.source step
);
  import erg_pkg::*;

  job_t job;
  logic job_valid, job_ready;

  erg_front #(.MAX_STEPS(MAX_STEPS)) u_front (
    .clk_i, .rst_ni, .req,
    .job_o(job), .job_valid_o(job_valid), .job_ready_i(job_ready)
  );

  erg_back #(.MAX_STEPS(MAX_STEPS)) u_back (
    .clk_i, .rst_ni,
    .job_i(job), .job_valid_i(job_valid), .job_ready_o(job_ready), .step
  );
endmodule
`default_nettype wire

/* sv/erg_checker.sv */
`default_nettype none
`include "euclidean_rhythm_generator_macros.svh"
module erg_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       step_valid_i,
  input wire logic       step_ready_i,
  input wire logic       step_last_i,
  input wire logic       step_bit_i,
  input wire logic [5:0] step_index_i
);
  `ERG_ASSERT_NEXT(a_hold, clk_i, rst_ni, step_valid_i && !step_ready_i, step_valid_i)
  `ERG_ASSERT_NEXT(a_idx_stable, clk_i, rst_ni, step_valid_i && !step_ready_i, $stable(step_index_i))
  `ERG_ASSERT_NEXT(a_flags_stable, clk_i, rst_ni, step_valid_i && !step_ready_i, $stable({step_last_i, step_bit_i}))
  `ERG_ASSERT_IMPL(a_last_idx, clk_i, rst_ni, step_valid_i && step_index_i == 6'd63, step_last_i)
endmodule

bind euclidean_rhythm_generator erg_checker u_erg_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .step_valid_i(step.valid), .step_ready_i(step.ready),
  .step_last_i(step.payload.last_step), .step_bit_i(step.payload.step_bit),
  .step_index_i(step.payload.step_index)
);
`default_nettype wire

/* tb/euclidean_rhythm_generator_tb.sv */
module euclidean_rhythm_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import erg_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned LongHold = 500;
  localparam int unsigned DrainCycles = 600;

  logic clk_i = 1'b0;
  logic rst_ni;

  erg_req_if  req_ch ();
  erg_step_if step_ch ();

  euclidean_rhythm_generator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .step   (step_ch)
  );

  always #10 clk_i = ~clk_i;

  req_t  pending_reqs[$];
  step_t expected_steps[$];
  bit    no_idle;
  bit    hold_sender;
  int    long_hold_req;
  int    long_hold_done;
  int    err_cnt;
  int    req_cnt;
  int    step_cnt;
  int    src_gap;
  int    snk_gap;
  int    snk_long;
  int    quiet_cycles;

  function automatic void predict_pattern(req_t r);
    logic [63:0] fb[64], bb[64], nfb[64], nbb[64];
    int          fl[64], bl[64], nfl[64], nbl[64];
    int          hits, len, fc, bc, pairs, nb, n;
    step_t       s;
    hits = (r.hit_count > MaxSteps) ? MaxSteps : r.hit_count;
    len = (r.pattern_length > MaxSteps) ? MaxSteps : r.pattern_length;
    fc = hits;
    bc = (len > hits) ? len - hits : 0;
    for (int i = 0; i < fc; i++) begin
      fb[i] = 64'd1;
      fl[i] = 1;
    end
    for (int i = 0; i < bc; i++) begin
      bb[i] = 64'd0;
      bl[i] = 1;
    end
    if (fc > 0) begin
      while (bc >= 2) begin
        pairs = (fc < bc) ? fc : bc;
        nb = 0;
        for (int i = 0; i < pairs; i++) begin
          nfb[i] = fb[fc-1-i] | ((fl[fc-1-i] < 64) ? (bb[bc-1-i] << fl[fc-1-i]) : 64'd0);
          nfl[i] = fl[fc-1-i] + bl[bc-1-i];
        end
        for (int i = 0; i + pairs < fc; i++) begin
          nbb[nb] = fb[i];
          nbl[nb] = fl[i];
          nb++;
        end
        for (int i = 0; i + pairs < bc; i++) begin
          nbb[nb] = bb[i];
          nbl[nb] = bl[i];
          nb++;
        end
        for (int i = 0; i < pairs; i++) begin
          fb[i] = nfb[i];
          fl[i] = nfl[i];
        end
        for (int i = 0; i < nb; i++) begin
          bb[i] = nbb[i];
          bl[i] = nbl[i];
        end
        fc = pairs;
        bc = nb;
      end
    end
    n = 0;
    for (int g = 0; g < fc + bc; g++) begin
      for (int b = 0; b < ((g < fc) ? fl[g] : bl[g-fc]) && b < 64 && n < MaxSteps; b++) begin
        s.step_bit = (g < fc) ? fb[g][b] : bb[g-fc][b];
        s.step_index = n[IdxW-1:0];
        s.last_step = 1'b0;
        expected_steps = {expected_steps, s};
        n++;
      end
    end
    if (n > 0) begin
      s = expected_steps[expected_steps.size() - 1];
      s.last_step = 1'b1;
      expected_steps[expected_steps.size() - 1] = s;
    end
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      src_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_pattern(req_ch.payload);
        req_cnt <= req_cnt + 1;
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          req_ch.payload <= pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          src_gap <= no_idle ? 0 : $urandom_range(0, 15);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Step monitor
  always @(posedge clk_i or negedge rst_ni) begin
    step_t exp_s;
    int    nxt_gap;
    int    nxt_long;
    if (!rst_ni) begin
      step_ch.ready <= 1'b0;
      snk_gap <= 0;
      snk_long <= 0;
    end else begin
      nxt_gap = (snk_gap > 0) ? snk_gap - 1 : 0;
      nxt_long = (snk_long > 0) ? snk_long - 1 : 0;
      if (step_ch.valid && step_ch.ready) begin
        step_cnt <= step_cnt + 1;
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected step item %p", $time, step_ch.payload);
          err_cnt = err_cnt + 1;
        end else begin
          exp_s = expected_steps.pop_front();
          if (exp_s.step_bit !== step_ch.payload.step_bit) begin
            $display("%0t: step_bit expected %0d actual %0d", $time, exp_s.step_bit,
                     step_ch.payload.step_bit);
            err_cnt = err_cnt + 1;
          end
          if (exp_s.step_index !== step_ch.payload.step_index) begin
            $display("%0t: step_index expected %0d actual %0d", $time, exp_s.step_index,
                     step_ch.payload.step_index);
            err_cnt = err_cnt + 1;
          end
          if (exp_s.last_step !== step_ch.payload.last_step) begin
            $display("%0t: last_step expected %0d actual %0d", $time, exp_s.last_step,
                     step_ch.payload.last_step);
            err_cnt = err_cnt + 1;
          end
        end
        nxt_gap = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (long_hold_req != long_hold_done) begin
        nxt_long = LongHold;
        long_hold_done <= long_hold_req;
      end
      snk_gap <= nxt_gap;
      snk_long <= nxt_long;
      step_ch.ready <= (nxt_gap == 0) && (nxt_long == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (step_ch.valid && step_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: timeout, %0d step items outstanding", $time, expected_steps.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_req(int unsigned hits, int unsigned len);
    req_t r;
    r.hit_count = hits[CntW-1:0];
    r.pattern_length = len[CntW-1:0];
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic add_random(int count);
    int unsigned len, sel;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        len = $urandom_range(0, 16);
        add_req($urandom_range(0, len + 1), len);
      end else if (sel < 95) begin
        len = $urandom_range(17, 64);
        add_req($urandom_range(0, len), len);
      end else begin
        add_req($urandom_range(0, 127), $urandom_range(0, 127));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_steps.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    step_ch.ready = 1'b0;
    err_cnt = 0;
    req_cnt = 0;
    step_cnt = 0;
    quiet_cycles = 0;
    long_hold_req = 0;
    long_hold_done = 0;
    no_idle = 1'b0;
    hold_sender = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_req(0, 0);
    add_req(0, 5);
    add_req(5, 0);
    add_req(1, 1);
    add_req(3, 8);
    add_req(5, 8);
    add_req(5, 13);
    add_req(7, 16);
    add_req(1, 64);
    add_req(64, 1);
    add_req(63, 64);
    add_req(64, 64);
    add_req(127, 127);
    add_req(127, 0);
    add_req(0, 127);
    add_req(100, 20);
    add_req(2, 64);
    add_req(13, 64);
    add_req(85, 42);
    add_req(42, 85);
    add_req(9, 7);
    wait_drained();

    no_idle = 1'b1;
    add_random(60);
    wait_drained();
    no_idle = 1'b0;

    long_hold_req = 1;
    add_random(40);
    wait_drained();

    hold_sender = 1'b1;
    add_random(10);
    repeat (40) @(posedge clk_i);
    hold_sender = 1'b0;
    add_random(170);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_steps.size() > 0) begin
      $display("%0d step items never arrived", expected_steps.size());
      err_cnt = err_cnt + expected_steps.size();
    end
    $display("Sent %0d rhythm requests and checked %0d step items, including", req_cnt,
             step_cnt);
    $display("saturated fields, zero hits, hits over length and long output stalls.");
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
